// File: design/tpd_pkg.sv
package tpd_pkg;

    localparam int HANDS         = 8;
    localparam int AVERAGE_DEPTH = 3;
    localparam int SLOT_W        = $clog2(HANDS);
    localparam int HIST_DEPTH    = HANDS * AVERAGE_DEPTH;
    localparam int HIST_AW       = $clog2(HIST_DEPTH);

    localparam int OP_W      = 2;
    localparam int ID_W      = 16;
    localparam int POS_W     = 20;
    localparam int STAT_W    = 3;
    localparam int THR_W     = 16;
    localparam int RATIO_W   = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 2;

    localparam int SUM_W  = 22;
    localparam int D_W    = 21;
    localparam int LEN_W  = 21;
    localparam int Q_W    = 42;
    localparam int MUL_W  = 24;
    localparam int PROD_W = 48;
    localparam int SAT_W  = 23;
    localparam int STEP_W = 5;

    localparam int SQRT_STEPS  = 21;
    localparam int SQRT_TOP    = 2 * (SQRT_STEPS - 1);
    localparam int DIV_STEPS   = 21;
    localparam int RECIP_SHIFT = 22;
    localparam int RATIO_FRAC  = 16;

    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd2;

    localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_CREATED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_DESTROYED = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR   = 2'd2;

    localparam logic [THR_W-1:0]   THR_RESET   = 16'd160;
    localparam logic [RATIO_W-1:0] CLOSE_RESET = 17'd0;
    localparam logic [RATIO_W-1:0] RATIO_ONE   = 17'd65536;

    localparam logic [MUL_W-1:0] RECIP_1 = 24'd4194304;
    localparam logic [MUL_W-1:0] RECIP_2 = 24'd2097152;
    localparam logic [MUL_W-1:0] RECIP_3 = 24'd1398102;

    localparam logic [PROD_W-1:0] RATIO_HALF = 48'd32768;

    localparam logic signed [POS_W-1:0] POS_HI = 20'sh7FFFF;
    localparam logic signed [POS_W-1:0] POS_LO = 20'sh80000;

    localparam logic [CNT_W-1:0] CNT_FULL  = 2'd3;
    localparam logic [CNT_W-1:0] RING_LAST = 2'd2;
    localparam logic [1:0]       COMP_LAST = 2'd2;

    localparam logic [2:0] MUL_AVG   = 3'd0;
    localparam logic [2:0] MUL_SQ    = 3'd1;
    localparam logic [2:0] MUL_THR   = 3'd2;
    localparam logic [2:0] MUL_DIV   = 3'd3;
    localparam logic [2:0] MUL_BLEND = 3'd4;

    typedef struct packed {
        logic       capture;
        logic       decide;
        logic       rd;
        logic       acc;
        logic       mul_go;
        logic [2:0] mul_sel;
        logic       avg_wr;
        logic       q_acc;
        logic       cmp;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_wr;
        logic       blend_wr;
        logic       finish;
        logic [1:0] comp;
        logic [1:0] k;
    } t_cmd;

    typedef struct packed {
        logic             upd;
        logic             out_free;
        logic             close;
        logic [CNT_W-1:0] n;
    } t_sts;

endpackage

// File: design/tpd_in_if.sv
interface tpd_in_if import tpd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic [ID_W-1:0]         hand_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;

    modport source (output valid, opcode, hand_id, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, opcode, hand_id, pos_x, pos_y, pos_z, output ready);
endinterface

// File: design/tpd_out_if.sv
interface tpd_out_if import tpd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic [ID_W-1:0]         out_id;
    logic signed [POS_W-1:0] smooth_x;
    logic signed [POS_W-1:0] smooth_y;
    logic signed [POS_W-1:0] smooth_z;

    modport source (output valid, status, out_id, smooth_x, smooth_y, smooth_z, input ready);
    modport sink (input valid, status, out_id, smooth_x, smooth_y, smooth_z, output ready);
endinterface

// File: design/tracked_point_denoiser_unit.sv
// tracked point denoiser
// keeps up to eight tracked points keyed by a 16-bit id and smooths their
// positions (1/16 mm, Q1.16 blend ratios)
// input channel i_in: one beat per create, update or destroy request
// output channel o_out: exactly one result beat per request, in order
// config port: i_cfg_we with i_cfg_idx selects threshold, close or far ratio;
// write only while no request is in flight
// one request at a time; the input is ready only while the sequencer idles
// create, destroy and unknown ids: result registered by the decide state once
// the output register is free; update: each history sample is read and summed,
// then per axis the average, its distance and square; inside the dead zone the
// close ratio blends the distance, outside it a square root and three divisions
// scale it by the excess over the threshold before the far ratio blends it
// the result sits in an output register, so the next request is taken while
// it waits; a stalled receiver only holds the sequencer once a second result
// is ready
// reset empties the point table and restores the default registers
module tracked_point_denoiser_unit import tpd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tpd_in_if.sink               i_in,
    tpd_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_in.ready = in_ready;

    tpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tpd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_opcode    (i_in.opcode),
        .i_hand_id   (i_in.hand_id),
        .i_pos_x     (i_in.pos_x),
        .i_pos_y     (i_in.pos_y),
        .i_pos_z     (i_in.pos_z),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_status    (o_out.status),
        .o_out_id    (o_out.out_id),
        .o_smooth_x  (o_out.smooth_x),
        .o_smooth_y  (o_out.smooth_y),
        .o_smooth_z  (o_out.smooth_z)
    );

    a_decide_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.decide && !sts.upd |-> sts.out_free)
        else $error("result loaded over a waiting beat");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> sts.out_free)
        else $error("update result loaded over a waiting beat");

    a_busy_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> !i_in.ready)
        else $error("input ready while a request is in flight");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.decide || cmd.finish))
        else $error("output beat without a finished request");

endmodule

// File: design/tpd_ctrl.sv
module tpd_ctrl import tpd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECIDE = 5'd1;
    localparam logic [4:0] S_RD     = 5'd2;
    localparam logic [4:0] S_ACC    = 5'd3;
    localparam logic [4:0] S_AVGM   = 5'd4;
    localparam logic [4:0] S_AVGW   = 5'd5;
    localparam logic [4:0] S_SQM    = 5'd6;
    localparam logic [4:0] S_SQW    = 5'd7;
    localparam logic [4:0] S_THRM   = 5'd8;
    localparam logic [4:0] S_CMP    = 5'd9;
    localparam logic [4:0] S_SQRT   = 5'd10;
    localparam logic [4:0] S_DIVM   = 5'd11;
    localparam logic [4:0] S_DIVI   = 5'd12;
    localparam logic [4:0] S_DIV    = 5'd13;
    localparam logic [4:0] S_DIVW   = 5'd14;
    localparam logic [4:0] S_BLM    = 5'd15;
    localparam logic [4:0] S_BLW    = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    logic [4:0]        r_state, n_state;
    logic [1:0]        r_c, n_c;
    logic [1:0]        r_k, n_k;
    logic [STEP_W-1:0] r_it, n_it;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_c     <= '0;
            r_k     <= '0;
            r_it    <= '0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_k     <= n_k;
            r_it    <= n_it;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_c        = r_c;
        n_k        = r_k;
        n_it       = r_it;
        o_cmd      = '0;
        o_cmd.comp = r_c;
        o_cmd.k    = r_k;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.upd) begin
                    o_cmd.decide = 1'b1;
                    n_k          = '0;
                    n_state      = S_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_k == i_sts.n - 2'd1) begin
                    n_c     = '0;
                    n_state = S_AVGM;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_RD;
                end
            end
            S_AVGM: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MUL_AVG;
                n_state       = S_AVGW;
            end
            S_AVGW: begin
                o_cmd.avg_wr = 1'b1;
                n_state      = S_SQM;
            end
            S_SQM: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MUL_SQ;
                n_state       = S_SQW;
            end
            S_SQW: begin
                o_cmd.q_acc = 1'b1;
                if (r_c == COMP_LAST) begin
                    n_state = S_THRM;
                end else begin
                    n_c     = r_c + 2'd1;
                    n_state = S_AVGM;
                end
            end
            S_THRM: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MUL_THR;
                n_state       = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_c       = '0;
                if (i_sts.close) begin
                    n_state = S_BLM;
                end else begin
                    n_it    = STEP_W'(SQRT_STEPS - 1);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_it == '0) begin
                    n_state = S_DIVM;
                end else begin
                    n_it = r_it - 1'b1;
                end
            end
            S_DIVM: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MUL_DIV;
                n_state       = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_it           = STEP_W'(DIV_STEPS - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_it == '0) begin
                    n_state = S_DIVW;
                end else begin
                    n_it = r_it - 1'b1;
                end
            end
            S_DIVW: begin
                o_cmd.div_wr = 1'b1;
                if (r_c == COMP_LAST) begin
                    n_c     = '0;
                    n_state = S_BLM;
                end else begin
                    n_c     = r_c + 2'd1;
                    n_state = S_DIVM;
                end
            end
            S_BLM: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MUL_BLEND;
                n_state       = S_BLW;
            end
            S_BLW: begin
                o_cmd.blend_wr = 1'b1;
                if (r_c == COMP_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_c     = r_c + 2'd1;
                    n_state = S_BLM;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: design/tpd_dp.sv
module tpd_dp import tpd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [ID_W-1:0]         i_hand_id,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [STAT_W-1:0]       o_status,
    output logic [ID_W-1:0]         o_out_id,
    output logic signed [POS_W-1:0] o_smooth_x,
    output logic signed [POS_W-1:0] o_smooth_y,
    output logic signed [POS_W-1:0] o_smooth_z
);

    logic [THR_W-1:0]   r_thr;
    logic [RATIO_W-1:0] r_close_ratio;
    logic [RATIO_W-1:0] r_far_ratio;

    logic [OP_W-1:0]         r_op;
    logic [ID_W-1:0]         r_id;
    logic signed [POS_W-1:0] r_p [3];

    logic                    r_valid [HANDS];
    logic [ID_W-1:0]         r_ident [HANDS];
    logic [CNT_W-1:0]        r_cnt   [HANDS];
    logic [CNT_W-1:0]        r_ring  [HANDS];
    logic signed [POS_W-1:0] r_smt   [HANDS][3];
    logic signed [POS_W-1:0] r_hist  [HIST_DEPTH][3];

    logic [SLOT_W-1:0]        r_slot;
    logic [CNT_W-1:0]         r_n;
    logic signed [POS_W-1:0]  r_sm    [3];
    logic signed [SUM_W-1:0]  r_sum   [3];
    logic signed [POS_W-1:0]  r_hrd   [3];
    logic signed [D_W-1:0]    r_d     [3];
    logic signed [D_W-1:0]    r_delta [3];
    logic signed [POS_W-1:0]  r_new   [3];
    logic [Q_W-1:0]           r_q;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_close;
    logic [Q_W-1:0]           r_v, r_res, r_bit;
    logic [Q_W-1:0]           r_rem, r_dvs;
    logic [D_W-1:0]           r_quo;

    logic                    r_ovalid;
    logic [STAT_W-1:0]       r_ostatus;
    logic [ID_W-1:0]         r_oid;
    logic signed [POS_W-1:0] r_oval [3];

    logic                    hit, free_ok, upd, out_free, close_now, load_out;
    logic [SLOT_W-1:0]       hslot, fslot;
    logic [HIST_AW-1:0]      wr_addr, rd_addr;
    logic [STAT_W-1:0]       dec_status;
    logic signed [POS_W-1:0] dec_val [3];
    logic [CNT_W-1:0]        cnt_next;

    logic                    av_neg;
    logic [SUM_W-1:0]        av_abs, av_a;
    logic [MUL_W-1:0]        av_recip;
    logic [D_W-1:0]          av_mag;
    logic signed [SUM_W-1:0] av_s, d_full;

    logic [LEN_W-1:0]        len, exc;
    logic [D_W-1:0]          d_abs;
    logic [RATIO_W-1:0]      ratio;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic [Q_W-1:0]          sq_t;

    logic                    bl_neg;
    logic [PROD_W-1:0]       bl_abs, bl_rnd;
    logic [D_W-1:0]          bl_mag;
    logic signed [SAT_W-1:0] bl_adj, bl_sum;
    logic signed [POS_W-1:0] bl_new;

    always_comb begin
        hit     = 1'b0;
        hslot   = '0;
        free_ok = 1'b0;
        fslot   = '0;
        for (int i = 0; i < HANDS; i++) begin
            if (!hit && r_valid[i] && r_ident[i] == r_id) begin
                hit   = 1'b1;
                hslot = SLOT_W'(i);
            end
            if (!free_ok && !r_valid[i]) begin
                free_ok = 1'b1;
                fslot   = SLOT_W'(i);
            end
        end
    end

    assign upd      = (r_op == OP_UPDATE) && hit;
    assign out_free = !r_ovalid || i_out_ready;
    assign wr_addr  = HIST_AW'(int'(hslot) * AVERAGE_DEPTH + int'(r_ring[hslot]));
    assign rd_addr  = HIST_AW'(int'(r_slot) * AVERAGE_DEPTH + int'(i_cmd.k));
    assign cnt_next = (r_cnt[hslot] == CNT_FULL) ? CNT_FULL : r_cnt[hslot] + 2'd1;
    assign close_now = r_q <= Q_W'(r_prod[31:0]);

    assign o_sts.upd      = upd;
    assign o_sts.out_free = out_free;
    assign o_sts.close    = close_now;
    assign o_sts.n        = r_n;

    always_comb begin
        dec_status = ST_UNKNOWN;
        for (int c = 0; c < 3; c++) begin
            dec_val[c] = '0;
        end
        case (r_op)
            OP_CREATE: begin
                if (hit) begin
                    dec_status = ST_CREATED;
                    for (int c = 0; c < 3; c++) begin
                        dec_val[c] = r_smt[hslot][c];
                    end
                end else if (free_ok) begin
                    dec_status = ST_CREATED;
                    for (int c = 0; c < 3; c++) begin
                        dec_val[c] = r_p[c];
                    end
                end else begin
                    dec_status = ST_FULL;
                end
            end
            OP_DESTROY: begin
                if (hit) begin
                    dec_status = ST_DESTROYED;
                    for (int c = 0; c < 3; c++) begin
                        dec_val[c] = r_smt[hslot][c];
                    end
                end
            end
            default: dec_status = ST_UNKNOWN;
        endcase
    end

    // average by reciprocal multiply, rounded half away from zero
    always_comb begin
        av_neg = r_sum[i_cmd.comp][SUM_W-1];
        av_abs = av_neg ? SUM_W'(-r_sum[i_cmd.comp]) : SUM_W'(r_sum[i_cmd.comp]);
        av_a   = av_abs + ((r_n != 2'd1) ? SUM_W'(1) : SUM_W'(0));
        case (r_n)
            2'd2:    av_recip = RECIP_2;
            2'd3:    av_recip = RECIP_3;
            default: av_recip = RECIP_1;
        endcase
        av_mag = r_prod[RECIP_SHIFT +: D_W];
        av_s   = av_neg ? -$signed({1'b0, av_mag}) : $signed({1'b0, av_mag});
        d_full = av_s - SUM_W'(r_sm[i_cmd.comp]);
    end

    always_comb begin
        len   = r_res[LEN_W-1:0];
        exc   = len - LEN_W'(r_thr);
        d_abs = r_d[i_cmd.comp][D_W-1] ? D_W'(-r_d[i_cmd.comp]) : D_W'(r_d[i_cmd.comp]);
        ratio = r_close ? r_close_ratio : r_far_ratio;
        sq_t  = r_res + r_bit;
        case (i_cmd.mul_sel)
            MUL_AVG: begin
                mul_a = $signed({2'b00, av_a});
                mul_b = $signed(av_recip);
            end
            MUL_SQ: begin
                mul_a = MUL_W'(r_d[i_cmd.comp]);
                mul_b = MUL_W'(r_d[i_cmd.comp]);
            end
            MUL_THR: begin
                mul_a = $signed({8'b0, r_thr});
                mul_b = $signed({8'b0, r_thr});
            end
            MUL_DIV: begin
                mul_a = $signed({3'b0, exc});
                mul_b = $signed({3'b0, d_abs});
            end
            MUL_BLEND: begin
                mul_a = $signed({7'b0, ratio});
                mul_b = MUL_W'(r_delta[i_cmd.comp]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // blend step with saturation
    always_comb begin
        bl_neg = r_prod[PROD_W-1];
        bl_abs = bl_neg ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        bl_rnd = bl_abs + RATIO_HALF;
        bl_mag = bl_rnd[RATIO_FRAC +: D_W];
        bl_adj = bl_neg ? -$signed({2'b00, bl_mag}) : $signed({2'b00, bl_mag});
        bl_sum = SAT_W'(r_sm[i_cmd.comp]) + bl_adj;
        if (bl_sum > SAT_W'(POS_HI)) begin
            bl_new = POS_HI;
        end else if (bl_sum < SAT_W'(POS_LO)) begin
            bl_new = POS_LO;
        end else begin
            bl_new = bl_sum[POS_W-1:0];
        end
    end

    assign load_out = (i_cmd.decide && !upd) || i_cmd.finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr         <= THR_RESET;
            r_close_ratio <= CLOSE_RESET;
            r_far_ratio   <= RATIO_ONE;
            r_ovalid      <= 1'b0;
            for (int i = 0; i < HANDS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THR: r_thr <= i_cfg_wdata[THR_W-1:0];
                    CFG_CLOSE: begin
                        if (i_cfg_wdata <= RATIO_ONE) r_close_ratio <= i_cfg_wdata;
                    end
                    CFG_FAR: begin
                        if (i_cfg_wdata <= RATIO_ONE) r_far_ratio <= i_cfg_wdata;
                    end
                    default: r_thr <= r_thr;
                endcase
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.decide) begin
                if (r_op == OP_CREATE && !hit && free_ok) begin
                    r_valid[fslot] <= 1'b1;
                end
                if (r_op == OP_DESTROY && hit) begin
                    r_valid[hslot] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_id   <= i_hand_id;
            r_p[0] <= i_pos_x;
            r_p[1] <= i_pos_y;
            r_p[2] <= i_pos_z;
        end
        if (i_cmd.decide) begin
            r_slot <= hslot;
            r_q    <= '0;
            for (int c = 0; c < 3; c++) begin
                r_sm[c]  <= r_smt[hslot][c];
                r_sum[c] <= '0;
            end
            if (r_op == OP_CREATE && !hit && free_ok) begin
                r_ident[fslot] <= r_id;
                r_cnt[fslot]   <= '0;
                r_ring[fslot]  <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_smt[fslot][c] <= r_p[c];
                end
            end
            if (upd) begin
                for (int c = 0; c < 3; c++) begin
                    r_hist[wr_addr][c] <= r_p[c];
                end
                r_ring[hslot] <= (r_ring[hslot] == RING_LAST) ? '0 : r_ring[hslot] + 2'd1;
                r_cnt[hslot]  <= cnt_next;
                r_n           <= cnt_next;
            end
        end
        if (i_cmd.rd) begin
            for (int c = 0; c < 3; c++) begin
                r_hrd[c] <= r_hist[rd_addr][c];
            end
        end
        if (i_cmd.acc) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_sum[c] + SUM_W'(r_hrd[c]);
            end
        end
        if (i_cmd.mul_go) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.avg_wr) begin
            r_d[i_cmd.comp] <= d_full[D_W-1:0];
        end
        if (i_cmd.q_acc) begin
            r_q <= r_q + r_prod[Q_W-1:0];
        end
        if (i_cmd.cmp) begin
            r_close <= close_now;
            r_v     <= r_q;
            r_res   <= '0;
            r_bit   <= Q_W'(1) << SQRT_TOP;
            if (close_now) begin
                for (int c = 0; c < 3; c++) begin
                    r_delta[c] <= r_d[c];
                end
            end
        end
        if (i_cmd.sqrt_step) begin
            if (r_v >= sq_t) begin
                r_v   <= r_v - sq_t;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            r_rem <= r_prod[Q_W-1:0] + Q_W'(len >> 1);
            r_dvs <= Q_W'(len) << (DIV_STEPS - 1);
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            if (r_rem >= r_dvs) begin
                r_rem <= r_rem - r_dvs;
                r_quo <= {r_quo[D_W-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[D_W-2:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
        end
        if (i_cmd.div_wr) begin
            r_delta[i_cmd.comp] <= r_d[i_cmd.comp][D_W-1] ? -$signed(r_quo) : $signed(r_quo);
        end
        if (i_cmd.blend_wr) begin
            r_new[i_cmd.comp] <= bl_new;
        end
        if (i_cmd.finish) begin
            for (int c = 0; c < 3; c++) begin
                r_smt[r_slot][c] <= r_new[c];
            end
        end
        if (load_out) begin
            r_oid <= r_id;
            if (i_cmd.finish) begin
                r_ostatus <= ST_UPDATED;
                for (int c = 0; c < 3; c++) begin
                    r_oval[c] <= r_new[c];
                end
            end else begin
                r_ostatus <= dec_status;
                for (int c = 0; c < 3; c++) begin
                    r_oval[c] <= dec_val[c];
                end
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_out_id    = r_oid;
    assign o_smooth_x  = r_oval[0];
    assign o_smooth_y  = r_oval[1];
    assign o_smooth_z  = r_oval[2];

endmodule
